// ===== src/acpu_pkg.sv =====
package acpu_pkg;

    localparam int MEM_DEPTH = 65536;

    localparam logic [15:0] STACK_PAGE = 16'hFF00;
    localparam logic [15:0] SP_CELL    = 16'hFFFF;

    // Item modes
    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_EXEC = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    // Opcodes
    localparam logic [7:0] OP_NOP     = 8'h00;
    localparam logic [7:0] OP_NOP_ALT = 8'h01;
    localparam logic [7:0] OP_OUT     = 8'h02;
    localparam logic [7:0] OP_CLC     = 8'h03;
    localparam logic [7:0] OP_SEC     = 8'h04;
    localparam logic [7:0] OP_SHL     = 8'h05;
    localparam logic [7:0] OP_ROL     = 8'h06;
    localparam logic [7:0] OP_SHR     = 8'h07;
    localparam logic [7:0] OP_ROR     = 8'h08;
    localparam logic [7:0] OP_INP     = 8'h0A;
    localparam logic [7:0] OP_NOT     = 8'h0B;
    localparam logic [7:0] OP_INC     = 8'h0C;
    localparam logic [7:0] OP_DEC     = 8'h0D;
    localparam logic [7:0] OP_LDI     = 8'h0E;
    localparam logic [7:0] OP_ALUI_LO = 8'h0F;
    localparam logic [7:0] OP_ALUI_HI = 8'h13;
    localparam logic [7:0] OP_JMP     = 8'h14;
    localparam logic [7:0] OP_LDA     = 8'h15;
    localparam logic [7:0] OP_STA     = 8'h16;
    localparam logic [7:0] OP_ALUA_LO = 8'h17;
    localparam logic [7:0] OP_ALUA_HI = 8'h1B;
    localparam logic [7:0] OP_JMPI    = 8'h1C;
    localparam logic [7:0] OP_LDP     = 8'h1D;
    localparam logic [7:0] OP_STP     = 8'h1E;
    localparam logic [7:0] OP_ALUP_LO = 8'h1F;
    localparam logic [7:0] OP_ALUP_HI = 8'h23;
    localparam logic [7:0] OP_CLB     = 8'h24;
    localparam logic [7:0] OP_MODB_HI = 8'h2B;
    localparam logic [7:0] OP_CLW     = 8'h2C;
    localparam logic [7:0] OP_MODW_HI = 8'h33;
    localparam logic [7:0] OP_LDS     = 8'h34;
    localparam logic [7:0] OP_STS     = 8'h35;
    localparam logic [7:0] OP_PUSH    = 8'h36;
    localparam logic [7:0] OP_POP     = 8'h37;
    localparam logic [7:0] OP_CALL    = 8'h38;
    localparam logic [7:0] OP_RET     = 8'h39;
    localparam logic [7:0] OP_BNE     = 8'h3A;
    localparam logic [7:0] OP_BEQ     = 8'h3B;
    localparam logic [7:0] OP_BCC     = 8'h3C;
    localparam logic [7:0] OP_BCS     = 8'h3D;
    localparam logic [7:0] OP_BPL     = 8'h3E;
    localparam logic [7:0] OP_BMI     = 8'h3F;

    // Memory address select
    localparam logic [2:0] A_PC     = 3'd0;
    localparam logic [2:0] A_T      = 3'd1;
    localparam logic [2:0] A_T1     = 3'd2;
    localparam logic [2:0] A_SPC    = 3'd3;
    localparam logic [2:0] A_STK    = 3'd4;
    localparam logic [2:0] A_STKOFF = 3'd5;
    localparam logic [2:0] A_IN     = 3'd6;
    localparam logic [2:0] A_CLR    = 3'd7;

    // Memory write data select
    localparam logic [3:0] W_IN    = 4'd0;
    localparam logic [3:0] W_ACC   = 4'd1;
    localparam logic [3:0] W_ZERO  = 4'd2;
    localparam logic [3:0] W_RLO   = 4'd3;
    localparam logic [3:0] W_RHI   = 4'd4;
    localparam logic [3:0] W_PCLO  = 4'd5;
    localparam logic [3:0] W_PCHI  = 4'd6;
    localparam logic [3:0] W_SPDEC = 4'd7;
    localparam logic [3:0] W_SPINC = 4'd8;

    typedef struct packed {
        logic [2:0] asel;
        logic       we;
        logic [3:0] wsel;
        logic       ld_in;
        logic       pc_inc;
        logic       ld_op;
        logic       ld_lo;
        logic       ld_hi;
        logic       ld_dat;
        logic       ld_sp;
        logic       sp_dec;
        logic       sp_inc;
        logic       ld_rd;
        logic       exec;
        logic       wexec;
        logic       set_halt;
        logic       clr_inc;
    } cmd_t;

    typedef struct packed {
        logic [7:0] op;
        logic [7:0] q;
        logic       halt;
        logic       clr_last;
    } stat_t;

endpackage

// ===== src/acpu_ctrl.sv =====
module acpu_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [1:0]     mode,
    input  acpu_pkg::stat_t stat,
    output acpu_pkg::cmd_t  cmd,
    output logic           busy,
    output logic           done
);
    import acpu_pkg::*;

    localparam logic [5:0] S_IDLE  = 6'd0;
    localparam logic [5:0] S_CLEAR = 6'd1;
    localparam logic [5:0] S_FETCH = 6'd2;
    localparam logic [5:0] S_DEC   = 6'd3;
    localparam logic [5:0] S_IMM   = 6'd4;
    localparam logic [5:0] S_A0    = 6'd5;
    localparam logic [5:0] S_A1    = 6'd6;
    localparam logic [5:0] S_A2    = 6'd7;
    localparam logic [5:0] S_P0    = 6'd8;
    localparam logic [5:0] S_P1    = 6'd9;
    localparam logic [5:0] S_P2    = 6'd10;
    localparam logic [5:0] S_RD    = 6'd11;
    localparam logic [5:0] S_WT    = 6'd12;
    localparam logic [5:0] S_R0    = 6'd13;
    localparam logic [5:0] S_R1    = 6'd14;
    localparam logic [5:0] S_WL    = 6'd15;
    localparam logic [5:0] S_WH    = 6'd16;
    localparam logic [5:0] S_S0    = 6'd17;
    localparam logic [5:0] S_S1    = 6'd18;
    localparam logic [5:0] S_PU    = 6'd19;
    localparam logic [5:0] S_PD    = 6'd20;
    localparam logic [5:0] S_PU2   = 6'd21;
    localparam logic [5:0] S_PD2   = 6'd22;
    localparam logic [5:0] S_PO    = 6'd23;
    localparam logic [5:0] S_PR    = 6'd24;
    localparam logic [5:0] S_PO2   = 6'd25;
    localparam logic [5:0] S_PR2   = 6'd26;
    localparam logic [5:0] S_SR    = 6'd27;
    localparam logic [5:0] S_SW    = 6'd28;
    localparam logic [5:0] S_EX    = 6'd29;
    localparam logic [5:0] S_FIN   = 6'd30;
    localparam logic [5:0] S_MW    = 6'd31;
    localparam logic [5:0] S_MR    = 6'd32;
    localparam logic [5:0] S_MRD   = 6'd33;

    logic [5:0] state_reg;
    logic [5:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.ld_in = 1'b1;
                    case (mode)
                        MODE_LOAD: state_next = S_MW;
                        MODE_EXEC: state_next = stat.halt ? S_FIN : S_FETCH;
                        MODE_READ: state_next = S_MR;
                        default:   state_next = S_FIN;
                    endcase
                end
            end
            S_CLEAR:
            begin
                cmd.asel    = A_CLR;
                cmd.we      = 1'b1;
                cmd.wsel    = W_ZERO;
                cmd.clr_inc = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_FETCH:
            begin
                cmd.asel   = A_PC;
                cmd.pc_inc = 1'b1;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                cmd.ld_op = 1'b1;
                // route on the opcode straight from memory
                unique case (stat.q) inside
                    [OP_NOP:OP_ROR], [OP_INP:OP_DEC]:        state_next = S_EX;
                    [OP_LDI:OP_ALUI_HI], OP_LDS, OP_STS:     state_next = S_IMM;
                    OP_PUSH, OP_POP, OP_RET:                 state_next = S_S0;
                    [OP_JMP:OP_MODW_HI], OP_CALL, [OP_BNE:OP_BMI]:
                        state_next = S_A0;
                    default:
                    begin
                        cmd.set_halt = 1'b1;
                        state_next   = S_FIN;
                    end
                endcase
            end
            S_IMM:
            begin
                cmd.asel   = A_PC;
                cmd.pc_inc = 1'b1;
                state_next = ((stat.op == OP_LDS) || (stat.op == OP_STS)) ? S_S0 : S_EX;
            end
            S_A0:
            begin
                cmd.asel   = A_PC;
                cmd.pc_inc = 1'b1;
                state_next = S_A1;
            end
            S_A1:
            begin
                cmd.asel   = A_PC;
                cmd.pc_inc = 1'b1;
                cmd.ld_lo  = 1'b1;
                state_next = S_A2;
            end
            S_A2:
            begin
                cmd.ld_hi = 1'b1;
                unique case (stat.op) inside
                    OP_JMP, [OP_BNE:OP_BMI]:  state_next = S_EX;
                    OP_CALL:                  state_next = S_S0;
                    OP_STA:                   state_next = S_WT;
                    [OP_JMPI:OP_ALUP_HI]:     state_next = S_P0;
                    [OP_CLW:OP_MODW_HI]:      state_next = S_R0;
                    default:                  state_next = S_RD;
                endcase
            end
            S_P0:
            begin
                cmd.asel   = A_T;
                state_next = S_P1;
            end
            S_P1:
            begin
                cmd.asel   = A_T1;
                cmd.ld_lo  = 1'b1;
                state_next = S_P2;
            end
            S_P2:
            begin
                cmd.ld_hi = 1'b1;
                unique case (stat.op)
                    OP_JMPI: state_next = S_EX;
                    OP_STP:  state_next = S_WT;
                    default: state_next = S_RD;
                endcase
            end
            S_RD:
            begin
                cmd.asel   = A_T;
                state_next = S_EX;
            end
            S_WT:
            begin
                cmd.asel   = A_T;
                cmd.we     = 1'b1;
                cmd.wsel   = W_ACC;
                state_next = S_FIN;
            end
            S_R0:
            begin
                cmd.asel   = A_T;
                state_next = S_R1;
            end
            S_R1:
            begin
                cmd.asel   = A_T1;
                cmd.ld_dat = 1'b1;
                state_next = S_WL;
            end
            S_WL:
            begin
                cmd.asel   = A_T;
                cmd.we     = 1'b1;
                cmd.wsel   = W_RLO;
                cmd.wexec  = 1'b1;
                state_next = S_WH;
            end
            S_WH:
            begin
                cmd.asel   = A_T1;
                cmd.we     = 1'b1;
                cmd.wsel   = W_RHI;
                state_next = S_FIN;
            end
            S_S0:
            begin
                cmd.asel   = A_SPC;
                cmd.ld_dat = 1'b1;
                state_next = S_S1;
            end
            S_S1:
            begin
                cmd.ld_sp = 1'b1;
                unique case (stat.op)
                    OP_PUSH, OP_CALL: state_next = S_PU;
                    OP_POP, OP_RET:   state_next = S_PO;
                    OP_LDS:           state_next = S_SR;
                    default:          state_next = S_SW;
                endcase
            end
            S_PU:
            begin
                cmd.asel   = A_STK;
                cmd.we     = 1'b1;
                cmd.wsel   = (stat.op == OP_PUSH) ? W_ACC : W_PCLO;
                state_next = S_PD;
            end
            S_PD:
            begin
                cmd.asel   = A_SPC;
                cmd.we     = 1'b1;
                cmd.wsel   = W_SPDEC;
                cmd.sp_dec = 1'b1;
                state_next = (stat.op == OP_PUSH) ? S_FIN : S_PU2;
            end
            S_PU2:
            begin
                cmd.asel   = A_STK;
                cmd.we     = 1'b1;
                cmd.wsel   = W_PCHI;
                state_next = S_PD2;
            end
            S_PD2:
            begin
                cmd.asel   = A_SPC;
                cmd.we     = 1'b1;
                cmd.wsel   = W_SPDEC;
                cmd.sp_dec = 1'b1;
                state_next = S_EX;
            end
            S_PO:
            begin
                cmd.asel   = A_SPC;
                cmd.we     = 1'b1;
                cmd.wsel   = W_SPINC;
                cmd.sp_inc = 1'b1;
                state_next = S_PR;
            end
            S_PR:
            begin
                cmd.asel   = A_STK;
                state_next = (stat.op == OP_RET) ? S_PO2 : S_EX;
            end
            S_PO2:
            begin
                // hold the high byte of the return address
                cmd.ld_dat = 1'b1;
                cmd.asel   = A_SPC;
                cmd.we     = 1'b1;
                cmd.wsel   = W_SPINC;
                cmd.sp_inc = 1'b1;
                state_next = S_PR2;
            end
            S_PR2:
            begin
                cmd.asel   = A_STK;
                state_next = S_EX;
            end
            S_SR:
            begin
                cmd.asel   = A_STKOFF;
                state_next = S_EX;
            end
            S_SW:
            begin
                cmd.asel   = A_STKOFF;
                cmd.we     = 1'b1;
                cmd.wsel   = W_ACC;
                state_next = S_FIN;
            end
            S_EX:
            begin
                cmd.exec = 1'b1;
                if ((stat.op >= OP_CLB) && (stat.op <= OP_MODB_HI))
                begin
                    cmd.asel = A_T;
                    cmd.we   = 1'b1;
                    cmd.wsel = W_RLO;
                end
                state_next = S_FIN;
            end
            S_FIN:
            begin
                state_next = S_IDLE;
            end
            S_MW:
            begin
                cmd.asel   = A_IN;
                cmd.we     = 1'b1;
                cmd.wsel   = W_IN;
                state_next = S_FIN;
            end
            S_MR:
            begin
                cmd.asel   = A_IN;
                state_next = S_MRD;
            end
            S_MRD:
            begin
                cmd.ld_rd  = 1'b1;
                state_next = S_FIN;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_FIN);

endmodule

// ===== src/acpu_dp.sv =====
module acpu_dp (
    input  logic            clk,
    input  logic            rst_n,
    input  acpu_pkg::cmd_t  cmd,
    output acpu_pkg::stat_t stat,
    input  logic [15:0]     address,
    input  logic [7:0]      write_data,
    output logic            char_valid,
    output logic [7:0]      char_code,
    output logic            halted,
    output logic [15:0]     program_counter,
    output logic [7:0]      accumulator,
    output logic            flag_neg,
    output logic            flag_carry,
    output logic            flag_zero,
    output logic [7:0]      read_data
);
    import acpu_pkg::*;

    logic [7:0]  mem_array [0:MEM_DEPTH-1];

    logic [15:0] pc_reg,  pc_next;
    logic [7:0]  acc_reg, acc_next;
    logic [2:0]  flg_reg, flg_next;   // {N, C, Z}
    logic        halt_reg, halt_next;
    logic [7:0]  op_reg;
    logic [15:0] t_reg;
    logic [7:0]  d_reg;
    logic [7:0]  sp_reg, sp_next;
    logic [15:0] rr_reg;
    logic [7:0]  q_reg;
    logic [15:0] clr_reg;
    logic [15:0] in_addr_reg;
    logic [7:0]  in_data_reg;
    logic        cv_reg, cv_next;
    logic [7:0]  cc_reg, cc_next;
    logic [7:0]  rd_reg;

    logic [15:0] mem_addr;
    logic [7:0]  mem_wd;
    logic        mod_word;
    logic [2:0]  mod_kind;
    logic [15:0] mod_x;
    logic [15:0] mod_r;
    logic [2:0]  mod_f;
    logic [2:0]  alu_kind;
    logic [15:0] alu_r;

    function automatic logic [2:0] flags8(input logic [15:0] r);
        flags8 = {r[7], |r[15:8], (r[7:0] == 8'h00)};
    endfunction

    always_comb
    begin
        case (cmd.asel)
            A_PC:     mem_addr = pc_reg;
            A_T:      mem_addr = t_reg;
            A_T1:     mem_addr = t_reg + 16'd1;
            A_SPC:    mem_addr = SP_CELL;
            A_STK:    mem_addr = {STACK_PAGE[15:8], sp_reg};
            A_STKOFF: mem_addr = STACK_PAGE + {8'h00, sp_reg} + {8'h00, d_reg};
            A_IN:     mem_addr = in_addr_reg;
            default:  mem_addr = clr_reg;
        endcase
    end

    // read-modify-write unit, byte or word
    always_comb
    begin
        mod_word = (op_reg >= OP_CLW) && (op_reg <= OP_MODW_HI);
        mod_kind = op_reg[2:0] + 3'd4;
        mod_x    = mod_word ? {q_reg, d_reg} : {8'h00, q_reg};
        case (mod_kind)
            3'd0:    mod_r = 16'h0000;
            3'd1:    mod_r = ~mod_x;
            3'd2:    mod_r = mod_x + 16'd1;
            3'd3:    mod_r = mod_x - 16'd1;
            3'd4:    mod_r = mod_x + {8'h00, acc_reg};
            3'd5:    mod_r = mod_x - {8'h00, acc_reg};
            3'd6:    mod_r = mod_x + {8'h00, acc_reg} + {15'd0, flg_reg[1]};
            default: mod_r = mod_x - {8'h00, acc_reg} - {15'd0, flg_reg[1]};
        endcase
        if (mod_kind == 3'd0)
        begin
            mod_f = 3'b010;
        end
        else if (mod_word)
        begin
            mod_f = {3{mod_r[15]}};
        end
        else
        begin
            mod_f = flags8(mod_r);
        end
    end

    always_comb
    begin
        alu_kind = op_reg[2:0] + 3'd1;
        case (alu_kind)
            3'd0:    alu_r = {8'h00, acc_reg} + {8'h00, q_reg};
            3'd3:    alu_r = {8'h00, acc_reg} + {8'h00, q_reg} + {15'd0, flg_reg[1]};
            3'd4:    alu_r = {8'h00, acc_reg} - {8'h00, q_reg} - {15'd0, flg_reg[1]};
            default: alu_r = {8'h00, acc_reg} - {8'h00, q_reg};
        endcase
    end

    always_comb
    begin
        case (cmd.wsel)
            W_IN:    mem_wd = in_data_reg;
            W_ACC:   mem_wd = acc_reg;
            W_RLO:   mem_wd = mod_r[7:0];
            W_RHI:   mem_wd = rr_reg[15:8];
            W_PCLO:  mem_wd = pc_reg[7:0];
            W_PCHI:  mem_wd = pc_reg[15:8];
            W_SPDEC: mem_wd = sp_reg - 8'd1;
            W_SPINC: mem_wd = sp_reg + 8'd1;
            default: mem_wd = 8'h00;
        endcase
    end

    always_comb
    begin
        logic [15:0] r;
        r         = 16'h0000;
        pc_next   = cmd.pc_inc ? pc_reg + 16'd1 : pc_reg;
        acc_next  = acc_reg;
        flg_next  = flg_reg;
        halt_next = halt_reg | cmd.set_halt;
        sp_next   = sp_reg;
        cv_next   = cv_reg;
        cc_next   = cc_reg;
        if (cmd.ld_sp)
        begin
            sp_next = q_reg;
        end
        else if (cmd.sp_dec)
        begin
            sp_next = sp_reg - 8'd1;
        end
        else if (cmd.sp_inc)
        begin
            sp_next = sp_reg + 8'd1;
        end
        if (cmd.ld_in)
        begin
            cv_next = 1'b0;
            cc_next = 8'h00;
        end
        if (cmd.wexec)
        begin
            flg_next = mod_f;
        end
        if (cmd.exec)
        begin
            unique case (op_reg) inside
                OP_OUT:
                begin
                    cv_next  = 1'b1;
                    cc_next  = acc_reg;
                    flg_next = 3'b100;
                end
                OP_CLC: flg_next = 3'b100;
                OP_SEC: flg_next = 3'b011;
                OP_SHL, OP_ROL, OP_SHR, OP_ROR, OP_NOT, OP_INC, OP_DEC:
                begin
                    case (op_reg)
                        OP_SHL:  r = {7'd0, acc_reg, 1'b0};
                        OP_ROL:  r = {7'd0, acc_reg, acc_reg[7]};
                        OP_SHR:  r = {9'd0, acc_reg[7:1]};
                        OP_ROR:  r = {8'd0, acc_reg[0], acc_reg[7:1]};
                        OP_NOT:  r = ~{8'h00, acc_reg};
                        OP_INC:  r = {8'h00, acc_reg} + 16'd1;
                        default: r = {8'h00, acc_reg} - 16'd1;
                    endcase
                    flg_next = flags8(r);
                    acc_next = r[7:0];
                end
                OP_INP:
                begin
                    acc_next = 8'h00;
                    flg_next = 3'b010;
                end
                OP_LDI, OP_LDA, OP_LDP, OP_LDS, OP_POP: acc_next = q_reg;
                [OP_ALUI_LO:OP_ALUI_HI], [OP_ALUA_LO:OP_ALUA_HI],
                [OP_ALUP_LO:OP_ALUP_HI]:
                begin
                    flg_next = flags8(alu_r);
                    // compare drops the result
                    if (alu_kind != 3'd2)
                    begin
                        acc_next = alu_r[7:0];
                    end
                end
                OP_JMP, OP_JMPI, OP_CALL: pc_next = t_reg;
                [OP_CLB:OP_MODB_HI]: flg_next = mod_f;
                OP_RET: pc_next = {d_reg, q_reg};
                OP_BNE: pc_next = flg_reg[0] ? pc_reg : t_reg;
                OP_BEQ: pc_next = flg_reg[0] ? t_reg : pc_reg;
                OP_BCC: pc_next = flg_reg[1] ? pc_reg : t_reg;
                OP_BCS: pc_next = flg_reg[1] ? t_reg : pc_reg;
                OP_BPL: pc_next = flg_reg[2] ? pc_reg : t_reg;
                OP_BMI: pc_next = flg_reg[2] ? t_reg : pc_reg;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.we)
        begin
            mem_array[mem_addr] <= mem_wd;
        end
        else
        begin
            q_reg <= mem_array[mem_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_op)
        begin
            op_reg <= q_reg;
        end
        if (cmd.ld_lo)
        begin
            t_reg[7:0] <= q_reg;
        end
        if (cmd.ld_hi)
        begin
            t_reg[15:8] <= q_reg;
        end
        if (cmd.ld_dat)
        begin
            d_reg <= q_reg;
        end
        if (cmd.wexec)
        begin
            rr_reg <= mod_r;
        end
        if (cmd.ld_in)
        begin
            in_addr_reg <= address;
            in_data_reg <= write_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= 16'h0000;
            acc_reg  <= 8'h00;
            flg_reg  <= 3'b000;
            halt_reg <= 1'b0;
            sp_reg   <= 8'h00;
            clr_reg  <= 16'h0000;
            cv_reg   <= 1'b0;
            cc_reg   <= 8'h00;
            rd_reg   <= 8'h00;
        end
        else
        begin
            pc_reg   <= pc_next;
            acc_reg  <= acc_next;
            flg_reg  <= flg_next;
            halt_reg <= halt_next;
            sp_reg   <= sp_next;
            cv_reg   <= cv_next;
            cc_reg   <= cc_next;
            if (cmd.clr_inc)
            begin
                clr_reg <= clr_reg + 16'd1;
            end
            if (cmd.ld_in)
            begin
                rd_reg <= 8'h00;
            end
            else if (cmd.ld_rd)
            begin
                rd_reg <= q_reg;
            end
        end
    end

    assign stat.op       = op_reg;
    assign stat.q        = q_reg;
    assign stat.halt     = halt_reg;
    assign stat.clr_last = (clr_reg == SP_CELL);

    assign char_valid      = cv_reg;
    assign char_code       = cc_reg;
    assign halted          = halt_reg;
    assign program_counter = pc_reg;
    assign accumulator     = acc_reg;
    assign flag_neg        = flg_reg[2];
    assign flag_carry      = flg_reg[1];
    assign flag_zero       = flg_reg[0];
    assign read_data       = rd_reg;

endmodule

// ===== src/accumulator_cpu_instruction_step_core.sv =====
// Channel   Handshake            Payload
// command   start / busy         mode, address, write_data
// result    done (one cycle)     char_valid, char_code, halted, program_counter,
//                                accumulator, flag_neg, flag_carry, flag_zero, read_data
//
// Each item (load, read, execute, or execute while halted or with an unknown mode) runs
// from start to done before the next is taken; the single-port byte memory allows one
// access a cycle.
// After reset the block sweeps the 65536-byte memory to zero, one byte a
// cycle, with busy high until the sweep ends.
// Results are shown for one cycle with done; the receiver cannot stall.
module accumulator_cpu_instruction_step_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [15:0] address,
    input  logic [7:0]  write_data,
    output logic        done,
    output logic        char_valid,
    output logic [7:0]  char_code,
    output logic        halted,
    output logic [15:0] program_counter,
    output logic [7:0]  accumulator,
    output logic        flag_neg,
    output logic        flag_carry,
    output logic        flag_zero,
    output logic [7:0]  read_data
);
    import acpu_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    acpu_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    acpu_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .address         (address),
        .write_data      (write_data),
        .char_valid      (char_valid),
        .char_code       (char_code),
        .halted          (halted),
        .program_counter (program_counter),
        .accumulator     (accumulator),
        .flag_neg        (flag_neg),
        .flag_carry      (flag_carry),
        .flag_zero       (flag_zero),
        .read_data       (read_data)
    );

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done without busy");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted but block not busy");

    a_out_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (done && char_valid) |-> (flag_neg && !flag_carry && !flag_zero && !halted))
        else $error("character out with wrong flags");

    a_mem_port: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.we |-> !cmd.ld_rd)
        else $error("memory write and read capture together");

endmodule

// ===== tb/sv/accumulator_cpu_instruction_step_checker.sv =====
`timescale 1ns / 100ps

module accumulator_cpu_instruction_step_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  mode,
    input  logic [15:0] address,
    input  logic [7:0]  write_data,
    input  logic        done,
    input  logic        char_valid,
    input  logic [7:0]  char_code,
    input  logic        halted,
    input  logic [15:0] program_counter,
    input  logic [7:0]  accumulator,
    input  logic        flag_neg,
    input  logic        flag_carry,
    input  logic        flag_zero,
    input  logic [7:0]  read_data,
    output int          errors,
    output int          outstanding
);
    import acpu_pkg::*;

    typedef struct packed {
        logic        cv;
        logic [7:0]  cc;
        logic        hlt;
        logic [15:0] pc;
        logic [7:0]  acc;
        logic        n;
        logic        c;
        logic        z;
        logic [7:0]  rd;
    } cpu_state_t;

    logic [7:0]  mem [0:MEM_DEPTH-1];
    logic [15:0] pc;
    logic [7:0]  acc;
    logic        fn, fc, fz, hlt;
    logic        out_v;
    logic [7:0]  out_c;
    cpu_state_t  expected_states[$];

    initial
    begin
        for (int i = 0; i < MEM_DEPTH; i++)
            mem[i] = 8'h00;
        pc = '0;
        acc = '0;
        {fn, fc, fz, hlt} = '0;
        errors = 0;
    end

    assign outstanding = expected_states.size();

    function automatic logic [7:0] fetch8();
        logic [7:0] b;
        b = mem[pc];
        pc = pc + 16'd1;
        return b;
    endfunction

    function automatic logic [15:0] fetch16();
        logic [7:0] lo;
        lo = fetch8();
        return {fetch8(), lo};
    endfunction

    function automatic logic [15:0] read16(logic [15:0] a);
        logic [15:0] a1;
        a1 = a + 16'd1;
        return {mem[a1], mem[a]};
    endfunction

    function automatic void write16(logic [15:0] a, logic [15:0] v);
        logic [15:0] a1;
        a1 = a + 16'd1;
        mem[a] = v[7:0];
        mem[a1] = v[15:8];
    endfunction

    function automatic void flags8(logic [15:0] r);
        fn = r[7];
        fc = (r > 16'h00FF);
        fz = (r[7:0] == 8'h00);
    endfunction

    function automatic void flags16(logic [15:0] r);
        {fn, fc, fz} = {3{r[15]}};
    endfunction

    function automatic void push8(logic [7:0] b);
        logic [7:0] sp;
        sp = mem[SP_CELL];
        mem[STACK_PAGE + {8'h00, sp}] = b;
        mem[SP_CELL] = sp - 8'd1;
    endfunction

    function automatic logic [7:0] pop8();
        logic [7:0] sp;
        sp = mem[SP_CELL] + 8'd1;
        mem[SP_CELL] = sp;
        return mem[STACK_PAGE + {8'h00, sp}];
    endfunction

    // kind: add, sub, compare, add with carry, sub with carry
    function automatic void alu(int kind, logic [7:0] v);
        logic [15:0] r;
        case (kind)
            0: r = {8'h00, acc} + {8'h00, v};
            3: r = {8'h00, acc} + {8'h00, v} + {15'd0, fc};
            4: r = {8'h00, acc} - {8'h00, v} - {15'd0, fc};
            default: r = {8'h00, acc} - {8'h00, v};
        endcase
        flags8(r);
        if (kind != 2)
            acc = r[7:0];
    endfunction

    function automatic logic [15:0] modify(int kind, logic [15:0] x);
        logic [15:0] a;
        a = {8'h00, acc};
        case (kind)
            1: return ~x;
            2: return x + 16'd1;
            3: return x - 16'd1;
            4: return x + a;
            5: return x - a;
            6: return x + a + {15'd0, fc};
            default: return x - a - {15'd0, fc};
        endcase
    endfunction

    function automatic void run_instruction();
        logic [7:0]  oc, v;
        logic [15:0] ea, r;
        oc = fetch8();
        if (oc >= OP_ALUI_LO && oc <= OP_ALUI_HI)
            alu(oc - OP_ALUI_LO, fetch8());
        else if (oc >= OP_ALUA_LO && oc <= OP_ALUA_HI)
            alu(oc - OP_ALUA_LO, mem[fetch16()]);
        else if (oc >= OP_ALUP_LO && oc <= OP_ALUP_HI)
            alu(oc - OP_ALUP_LO, mem[read16(fetch16())]);
        else if (oc >= OP_CLB && oc <= OP_MODB_HI)
        begin
            ea = fetch16();
            if (oc == OP_CLB)
            begin
                mem[ea] = 8'h00;
                {fn, fc, fz} = 3'b010;
            end
            else
            begin
                r = modify(oc - OP_CLB, {8'h00, mem[ea]});
                flags8(r);
                mem[ea] = r[7:0];
            end
        end
        else if (oc >= OP_CLW && oc <= OP_MODW_HI)
        begin
            ea = fetch16();
            if (oc == OP_CLW)
            begin
                write16(ea, 16'h0000);
                {fn, fc, fz} = 3'b010;
            end
            else
            begin
                r = modify(oc - OP_CLW, read16(ea));
                flags16(r);
                write16(ea, r);
            end
        end
        else
        begin
            case (oc)
                OP_NOP, OP_NOP_ALT: ;
                OP_OUT:
                begin
                    out_v = 1'b1;
                    out_c = acc;
                    {fn, fc, fz} = 3'b100;
                end
                OP_CLC: {fn, fc, fz} = 3'b100;
                OP_SEC: {fn, fc, fz} = 3'b011;
                OP_SHL:
                begin
                    r = {7'd0, acc, 1'b0};
                    flags8(r);
                    acc = r[7:0];
                end
                OP_ROL:
                begin
                    r = {7'd0, acc, acc[7]};
                    flags8(r);
                    acc = r[7:0];
                end
                OP_SHR:
                begin
                    r = {9'd0, acc[7:1]};
                    flags8(r);
                    acc = r[7:0];
                end
                OP_ROR:
                begin
                    r = {8'd0, acc[0], acc[7:1]};
                    flags8(r);
                    acc = r[7:0];
                end
                OP_INP:
                begin
                    acc = 8'h00;
                    flags8(16'h0000 - 16'h00FF);
                end
                OP_NOT:
                begin
                    r = ~{8'h00, acc};
                    flags8(r);
                    acc = r[7:0];
                end
                OP_INC:
                begin
                    r = {8'h00, acc} + 16'd1;
                    flags8(r);
                    acc = r[7:0];
                end
                OP_DEC:
                begin
                    r = {8'h00, acc} - 16'd1;
                    flags8(r);
                    acc = r[7:0];
                end
                OP_LDI: acc = fetch8();
                OP_JMP: pc = fetch16();
                OP_LDA: acc = mem[fetch16()];
                OP_STA: mem[fetch16()] = acc;
                OP_JMPI: pc = read16(fetch16());
                OP_LDP: acc = mem[read16(fetch16())];
                OP_STP: mem[read16(fetch16())] = acc;
                OP_LDS:
                begin
                    v = fetch8();
                    acc = mem[STACK_PAGE + {8'h00, mem[SP_CELL]} + {8'h00, v}];
                end
                OP_STS:
                begin
                    v = fetch8();
                    mem[STACK_PAGE + {8'h00, mem[SP_CELL]} + {8'h00, v}] = acc;
                end
                OP_PUSH: push8(acc);
                OP_POP: acc = pop8();
                OP_CALL:
                begin
                    ea = fetch16();
                    push8(pc[7:0]);
                    push8(pc[15:8]);
                    pc = ea;
                end
                OP_RET:
                begin
                    v = pop8();
                    pc = {v, pop8()};
                end
                OP_BNE: begin ea = fetch16(); if (!fz) pc = ea; end
                OP_BEQ: begin ea = fetch16(); if (fz) pc = ea; end
                OP_BCC: begin ea = fetch16(); if (!fc) pc = ea; end
                OP_BCS: begin ea = fetch16(); if (fc) pc = ea; end
                OP_BPL: begin ea = fetch16(); if (!fn) pc = ea; end
                OP_BMI: begin ea = fetch16(); if (fn) pc = ea; end
                default: hlt = 1'b1;
            endcase
        end
    endfunction

    function automatic cpu_state_t predict_step(logic [1:0] m, logic [15:0] a, logic [7:0] d);
        cpu_state_t s;
        logic [7:0] rd;
        out_v = 1'b0;
        out_c = 8'h00;
        rd = 8'h00;
        if (m == MODE_LOAD)
            mem[a] = d;
        else if (m == MODE_READ)
            rd = mem[a];
        else if (m == MODE_EXEC && !hlt)
            run_instruction();
        s = '{out_v, out_c, hlt, pc, acc, fn, fc, fz, rd};
        return s;
    endfunction

    task automatic report(string field, logic [15:0] got, logic [15:0] want);
        $display("%0t ns: %s mismatch: got %h, expected %h", $time, field, got, want);
        errors++;
    endtask

    task automatic compare_field(string field, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            report(field, got, want);
    endtask

    always @(posedge clk)
    begin
        cpu_state_t e;
        if (rst_n && done)
        begin
            if (expected_states.size() == 0)
                report("unexpected result", 16'h0, 16'h0);
            else
            begin
                e = expected_states.pop_front();
                compare_field("char_valid", char_valid, e.cv);
                compare_field("char_code", char_code, e.cc);
                compare_field("halted", halted, e.hlt);
                compare_field("program_counter", program_counter, e.pc);
                compare_field("accumulator", accumulator, e.acc);
                compare_field("flag_neg", flag_neg, e.n);
                compare_field("flag_carry", flag_carry, e.c);
                compare_field("flag_zero", flag_zero, e.z);
                compare_field("read_data", read_data, e.rd);
            end
        end
        if (rst_n && start && !busy)
            expected_states.push_back(predict_step(mode, address, write_data));
    end

endmodule

// ===== tb/sv/accumulator_cpu_instruction_step_core_test.sv =====
`timescale 1ns / 100ps

module accumulator_cpu_instruction_step_core_test;
    import acpu_pkg::*;

    localparam logic [7:0] OP_BAD_FIRST = 8'h09;
    localparam logic [7:0] OP_BAD_HIGH  = 8'hC0;
    localparam logic [1:0] MODE_NONE    = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  mode;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic        done;
    logic        char_valid;
    logic [7:0]  char_code;
    logic        halted;
    logic [15:0] program_counter;
    logic [7:0]  accumulator;
    logic        flag_neg;
    logic        flag_carry;
    logic        flag_zero;
    logic [7:0]  read_data;
    int          errors;
    int          outstanding;
    int          items_sent;
    int          results_seen;
    logic [15:0] last_pc;

    accumulator_cpu_instruction_step_core uut (.*);

    accumulator_cpu_instruction_step_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #1_500_000;
        $display("accumulator_cpu_instruction_step_core_test: errors");
        $finish;
    end

    always @(posedge clk)
    begin
        if (done)
        begin
            results_seen <= results_seen + 1;
            last_pc <= program_counter;
        end
    end

    task automatic send(logic [1:0] m, logic [15:0] a, logic [7:0] d);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        mode <= m;
        address <= a;
        write_data <= d;
        do @(posedge clk); while (busy);
        items_sent++;
    endtask

    // drop start and hold until every item has its result
    task automatic settle();
        start <= 1'b0;
        do @(posedge clk); while (results_seen != items_sent);
    endtask

    task automatic run_op(logic [7:0] op, logic [7:0] b1, logic [7:0] b2);
        logic [15:0] p;
        settle();
        p = last_pc;
        send(MODE_LOAD, p, op);
        send(MODE_LOAD, p + 16'd1, b1);
        send(MODE_LOAD, p + 16'd2, b2);
        send(MODE_EXEC, 16'($urandom), 8'($urandom));
    endtask

    function automatic logic [7:0] hot_page();
        case ($urandom_range(0, 3))
            0: return 8'h40;
            1: return 8'hFF;
            2: return 8'h41;
            default: return 8'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [7:0] op;
        start = 1'b0;
        mode = MODE_LOAD;
        address = '0;
        write_data = '0;
        rst_n = 1'b0;
        items_sent = 0;
        results_seen = 0;
        last_pc = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // extremes of load and read, then an unknown mode
        send(MODE_LOAD, 16'hFFFF, 8'hFF);
        send(MODE_READ, 16'hFFFF, 8'h00);
        send(MODE_READ, 16'h0000, 8'hFF);
        send(MODE_NONE, 16'h5555, 8'hAA);
        run_op(OP_OUT, 8'h00, 8'h00);
        run_op(OP_LDI, 8'hFF, 8'h00);
        run_op(OP_ALUI_LO, 8'h01, 8'h00);          // add wraps to zero with carry
        run_op(OP_ALUI_LO + 8'd4, 8'h01, 8'h00);   // subtract with borrow
        run_op(OP_ALUI_LO + 8'd3, 8'hFF, 8'h00);
        run_op(OP_ROL, 8'h00, 8'h00);
        run_op(OP_INP, 8'h00, 8'h00);
        run_op(OP_DEC, 8'h00, 8'h00);
        run_op(OP_CLW, 8'hFF, 8'hFF);              // word straddles the address wrap
        run_op(OP_MODW_HI - 8'd4, 8'hFF, 8'hFF);   // word decrement at the top
        run_op(OP_CALL, 8'h00, 8'h40);
        run_op(OP_RET, 8'h00, 8'h00);
        run_op(OP_JMP, 8'hFE, 8'hFF);              // program counter wraps past 0xFFFF

        while (items_sent < 750)
        begin
            if ($urandom_range(0, 2) == 0)
                send(MODE_LOAD, {hot_page(), 8'($urandom)}, 8'($urandom));
            if ($urandom_range(0, 3) == 0)
                send(MODE_READ, {hot_page(), 8'($urandom)}, 8'($urandom));
            if ($urandom_range(0, 30) == 0)
                send(MODE_NONE, 16'($urandom), 8'($urandom));
            do op = 8'($urandom_range(0, 63)); while (op == OP_BAD_FIRST);
            run_op(op, 8'($urandom), hot_page());
        end

        // halt is sticky: only load and read still act afterward
        run_op(OP_BAD_FIRST, 8'h00, 8'h00);
        send(MODE_EXEC, 16'h0000, 8'h00);
        send(MODE_LOAD, 16'h4000, 8'h5A);
        send(MODE_READ, 16'h4000, 8'h00);
        run_op(OP_BAD_HIGH, 8'h00, 8'h00);

        settle();
        repeat (20) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("accumulator_cpu_instruction_step_core_test: clean");
        else
            $display("accumulator_cpu_instruction_step_core_test: errors");
        $finish;
    end

endmodule
